// ===== hdl/wsd_pkg.sv =====
package wsd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned CNT_W    = 3;

    localparam logic [OPCODE_W-1:0] OPC_TEXT   = 4'h1;
    localparam logic [OPCODE_W-1:0] OPC_BINARY = 4'h2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [CNT_W-1:0] CNT_EXT16 = 3'd1;
    localparam logic [CNT_W-1:0] CNT_EXT64 = 3'd7;
    localparam logic [CNT_W-1:0] CNT_MASK  = 3'd3;

    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              has_byte;
        logic              frame_kind;
        logic              last_of_frame;
    } result_t;

endpackage

// ===== hdl/wsd_in_stage.sv =====
module wsd_in_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [wsd_pkg::BYTE_W-1:0] data_byte,
    input  logic                       advance,
    output logic                       held_valid,
    output logic [wsd_pkg::BYTE_W-1:0] held_byte
);
    import wsd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // stage frees up when empty or when its byte moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// ===== hdl/wsd_parser.sv =====
module wsd_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [wsd_pkg::BYTE_W-1:0] data_byte,
    output logic                       res_valid,
    output wsd_pkg::result_t           res
);
    import wsd_pkg::*;

    phase_t              phase_reg,   phase_next;
    logic [CNT_W-1:0]    hdr_cnt_reg, hdr_cnt_next;
    logic [OPCODE_W-1:0] opcode_reg,  opcode_next;
    logic                mask_reg,    mask_next;
    logic [LEN_W-1:0]    remain_reg,  remain_next;
    logic [KEY_W-1:0]    key_reg,     key_next;
    logic [1:0]          key_idx_reg, key_idx_next;

    logic              is_data;
    logic [6:0]        len7;
    logic [LEN_W-1:0]  ext_len;
    logic [KEY_W-1:0]  key_shift;
    logic [BYTE_W-1:0] key_byte;

    assign is_data   = (opcode_reg == OPC_TEXT) || (opcode_reg == OPC_BINARY);
    assign len7      = data_byte[6:0];
    assign ext_len   = {remain_reg[LEN_W-BYTE_W-1:0], data_byte};
    assign key_shift = {key_reg[KEY_W-BYTE_W-1:0], data_byte};

    always_comb
    begin
        unique case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        opcode_next  = opcode_reg;
        mask_next    = mask_reg;
        remain_next  = remain_reg;
        key_next     = key_reg;
        key_idx_next = key_idx_reg;

        res_valid         = 1'b0;
        res.payload_byte  = '0;
        res.has_byte      = 1'b0;
        res.frame_kind    = (opcode_reg == OPC_BINARY);
        res.last_of_frame = 1'b1;

        unique case (phase_reg)
            PH_HDR1:
            begin
                mask_next = data_byte[7];
                if ((len7 == LEN7_EXT16) || (len7 == LEN7_EXT64))
                begin
                    remain_next  = '0;
                    hdr_cnt_next = (len7 == LEN7_EXT16) ? CNT_EXT16 : CNT_EXT64;
                    phase_next   = PH_EXTLEN;
                end
                else
                begin
                    remain_next = {{(LEN_W-7){1'b0}}, len7};
                    if (data_byte[7])
                    begin
                        key_next     = '0;
                        hdr_cnt_next = CNT_MASK;
                        phase_next   = PH_MASK;
                    end
                    else
                    begin
                        key_idx_next = '0;
                        if (len7 == 7'd0)
                        begin
                            phase_next = PH_HDR0;
                            res_valid  = is_data;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end

            PH_EXTLEN:
            begin
                remain_next = ext_len;
                if (hdr_cnt_reg == '0)
                begin
                    if (mask_reg)
                    begin
                        key_next     = '0;
                        hdr_cnt_next = CNT_MASK;
                        phase_next   = PH_MASK;
                    end
                    else
                    begin
                        key_idx_next = '0;
                        if (ext_len == '0)
                        begin
                            phase_next = PH_HDR0;
                            res_valid  = is_data;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg - CNT_W'(1);
                end
            end

            PH_MASK:
            begin
                key_next = key_shift;
                if (hdr_cnt_reg == '0)
                begin
                    key_idx_next = '0;
                    if (remain_reg == '0)
                    begin
                        phase_next = PH_HDR0;
                        res_valid  = is_data;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg - CNT_W'(1);
                end
            end

            PH_PAYLOAD:
            begin
                key_idx_next = key_idx_reg + 2'd1;
                remain_next  = remain_reg - LEN_W'(1);
                if (remain_reg == LEN_W'(1))
                begin
                    phase_next = PH_HDR0;
                end
                res_valid         = is_data;
                res.payload_byte  = data_byte ^ (mask_reg ? key_byte : '0);
                res.has_byte      = 1'b1;
                res.last_of_frame = (remain_reg == LEN_W'(1));
            end

            default:
            begin
                // header byte 0, also any phase code with no meaning
                opcode_next = data_byte[OPCODE_W-1:0];
                phase_next  = PH_HDR1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            hdr_cnt_reg <= '0;
            opcode_reg  <= '0;
            mask_reg    <= 1'b0;
            remain_reg  <= '0;
            key_reg     <= '0;
            key_idx_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            opcode_reg  <= opcode_next;
            mask_reg    <= mask_next;
            remain_reg  <= remain_next;
            key_reg     <= key_next;
            key_idx_reg <= key_idx_next;
        end
    end

endmodule

// ===== hdl/wsd_out_reg.sv =====
module wsd_out_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       res_valid,
    input  wsd_pkg::result_t           res,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [wsd_pkg::BYTE_W-1:0] payload_byte,
    output logic                       has_byte,
    output logic                       frame_kind,
    output logic                       last_of_frame
);
    import wsd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // load only happens when the register is empty or being drained
    always_comb
    begin
        priority if (load)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign payload_byte  = res_reg.payload_byte;
    assign has_byte      = res_reg.has_byte;
    assign frame_kind    = res_reg.frame_kind;
    assign last_of_frame = res_reg.last_of_frame;

endmodule

// ===== hdl/websocket_frame_deframer_top.sv =====
// websocket frame deframer: takes the received stream of a websocket connection one
// byte per transaction and parses each frame header (opcode, mask bit, 7-bit length,
// optional 16- or 64-bit big-endian extended length, optional 4-byte mask key); payload
// bytes are unmasked with a rotating key index and, for text and binary frames, given
// out one per result transaction with last_of_frame on the final one, while an empty
// text or binary frame gives a single result with has_byte low; other opcodes are
// consumed with no results. one byte is taken per cycle at full rate: a byte sits in an
// input register, is parsed by a single step of header/payload logic (the widest piece
// being the 64-bit length decrement and compare) and its result, if any, is written to
// an output register, so a result is presented from the output register once its byte has
// passed the input register and the parse step. while a result waits on the output with
// out_ready low, parsing stalls: the input register still takes one more byte, then
// in_ready stays low until the waiting result is taken.
module websocket_frame_deframer_top (
    input  logic                       clk,
    input  logic                       rst_n,
    // input byte stream
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [wsd_pkg::BYTE_W-1:0] data_byte,
    // result stream
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [wsd_pkg::BYTE_W-1:0] payload_byte,
    output logic                       has_byte,
    output logic                       frame_kind,
    output logic                       last_of_frame
);
    import wsd_pkg::*;

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              advance;
    logic              res_valid;
    result_t           res;

    // the held byte is parsed once the output register can take whatever it yields
    assign advance = held_valid && (!out_valid || out_ready);

    // input register
    wsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    // frame state and per-byte step
    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    wsd_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .res_valid     (res_valid),
        .res           (res),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .has_byte      (has_byte),
        .frame_kind    (frame_kind),
        .last_of_frame (last_of_frame)
    );

endmodule
